// ===== src/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C master bit engine: command codes,
// phase limits and the tick record that travels from front to back.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    // Command codes (bus mode field)
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;
    localparam logic [2:0] CMD_ACK   = 3'd5;

    // Bits per byte on the bus
    localparam int unsigned BITS = 8;

    // Phase tick count after reset
    localparam logic [15:0] PHASE_TICKS_RST = 16'd50;

    // Stream widths
    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned S_TUSER_W = 3;
    localparam int unsigned M_TDATA_W = 16;

    typedef logic [2:0] cmd_t;

    // One tick after classification
    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] tx_byte;
        logic       ack_level;
        logic       sda_in;
    } tick_t;

    // Index of the last waveform phase of a command
    function automatic logic [5:0] last_phase(input cmd_t cmd);
        logic [5:0] lp;
        case (cmd)
            CMD_START: lp = 6'd3;
            CMD_STOP:  lp = 6'd2;
            CMD_WRITE: lp = 6'(3 * BITS + 3);
            CMD_READ:  lp = 6'(4 * BITS);
            CMD_ACK:   lp = 6'd2;
            default:   lp = 6'd0;
        endcase
        return lp;
    endfunction

endpackage

// ===== src/i2cm_front.sv =====
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts tick requests, folds unused modes to no-op and holds them in a
// two-entry queue for the bus engine.
// ----------------------------------------------------------------------------
module i2cm_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [i2cm_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [i2cm_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           q_valid,
    input  logic                           q_ready,
    output i2cm_pkg::tick_t                q_data
);
    import i2cm_pkg::*;

    tick_t      mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    tick_t      in_tick;
    logic       push;
    logic       pop;

    // Classify: modes outside start..ack act as no command
    always_comb begin
        in_tick.tx_byte   = s_tdata[7:0];
        in_tick.ack_level = s_tdata[8];
        in_tick.sda_in    = s_tdata[9];
        if (s_tuser >= CMD_START && s_tuser <= CMD_ACK) begin
            in_tick.cmd = s_tuser;
        end else begin
            in_tick.cmd = CMD_NONE;
        end
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_data   = mem_reg[rd_ptr_reg];

    // Queue pointers and fill
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_tick;
        end
    end

    // Checks
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("queue fill out of range");

    a_ptr_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with fill");

    a_empty_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with split pointers");

endmodule

// ===== src/i2cm_back.sv =====
// ----------------------------------------------------------------------------
// i2cm_back
// Bus engine: steps the command waveform one tick per request and registers
// the line levels and status into the result stage.
// ----------------------------------------------------------------------------
module i2cm_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [15:0]                    phase_ticks,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  i2cm_pkg::tick_t                q_data,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [i2cm_pkg::M_TDATA_W-1:0] m_tdata
);
    import i2cm_pkg::*;

    cmd_t        cmd_reg, cmd_next;
    logic [5:0]  phase_reg, phase_next;
    logic [1:0]  sub_reg, sub_next;
    logic [15:0] tick_reg, tick_next;
    logic [7:0]  shift_reg, shift_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        ack_reg, ack_next;
    logic [7:0]  rx_reg, rx_next;
    logic        ackl_reg, ackl_next;
    logic        done_next;
    logic        m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [15:0] pt;
    logic [5:0]  p;
    logic [5:0]  rp;
    logic        pop;

    assign q_ready  = !m_tvalid_reg || m_tready;
    assign pop      = q_valid && q_ready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A zero phase length behaves as one tick
    assign pt = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
    assign p  = phase_reg + 6'd1;
    assign rp = p - 6'd1;

    // Engine step for one tick
    always_comb begin
        cmd_next   = cmd_reg;
        phase_next = phase_reg;
        sub_next   = sub_reg;
        tick_next  = tick_reg;
        shift_next = shift_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        ack_next   = ack_reg;
        rx_next    = rx_reg;
        ackl_next  = ackl_reg;
        done_next  = 1'b0;
        if (pop) begin
            if (cmd_reg == CMD_NONE) begin
                if (q_data.cmd != CMD_NONE) begin
                    // launch: phase 0 of the new command
                    cmd_next   = q_data.cmd;
                    phase_next = 6'd0;
                    sub_next   = 2'd0;
                    tick_next  = 16'd0;
                    ackl_next  = q_data.ack_level;
                    case (q_data.cmd)
                        CMD_START: sda_next = 1'b1;
                        CMD_STOP:  sda_next = 1'b0;
                        CMD_WRITE: begin
                            sda_next   = q_data.tx_byte[7];
                            shift_next = {q_data.tx_byte[6:0], 1'b0};
                        end
                        CMD_READ: begin
                            sda_next   = 1'b1;
                            shift_next = 8'd0;
                        end
                        CMD_ACK:   sda_next = !q_data.ack_level;
                        default:   sda_next = sda_reg;
                    endcase
                end
            end else if (({1'b0, tick_reg} + 17'd1) >= {1'b0, pt}) begin
                tick_next = 16'd0;
                if (phase_reg >= last_phase(cmd_reg)) begin
                    // completion
                    if (cmd_reg == CMD_READ) begin
                        rx_next = shift_reg;
                    end
                    cmd_next   = CMD_NONE;
                    phase_next = 6'd0;
                    done_next  = 1'b1;
                end else begin
                    phase_next = p;
                    sub_next   = (sub_reg == 2'd2) ? 2'd0 : sub_reg + 2'd1;
                    case (cmd_reg)
                        CMD_START: begin
                            if (p == 6'd1) begin
                                scl_next = 1'b1;
                            end else if (p == 6'd2) begin
                                sda_next = 1'b0;
                            end else begin
                                scl_next = 1'b0;
                            end
                        end
                        CMD_STOP: begin
                            if (p == 6'd1) begin
                                scl_next = 1'b1;
                            end else begin
                                sda_next = 1'b1;
                            end
                        end
                        CMD_WRITE: begin
                            if (p < 6'(3 * BITS)) begin
                                // data bits: set SDA, raise SCL, lower SCL
                                case (sub_next)
                                    2'd0: begin
                                        sda_next   = shift_reg[7];
                                        shift_next = {shift_reg[6:0], 1'b0};
                                    end
                                    2'd1:    scl_next = 1'b1;
                                    default: scl_next = 1'b0;
                                endcase
                            end else begin
                                // acknowledge slot, SDA released first
                                case (p[1:0])
                                    2'd0:    sda_next = 1'b1;
                                    2'd1:    scl_next = 1'b1;
                                    2'd2:    ack_next = !q_data.sda_in;
                                    default: scl_next = 1'b0;
                                endcase
                            end
                        end
                        CMD_READ: begin
                            if (p == 6'(4 * BITS)) begin
                                scl_next = 1'b0;
                            end else begin
                                case (rp[1:0])
                                    2'd0: scl_next = 1'b0;
                                    2'd1: scl_next = 1'b1;
                                    2'd2: shift_next = {shift_reg[6:0], q_data.sda_in};
                                    default: shift_next = shift_reg;
                                endcase
                            end
                        end
                        CMD_ACK: begin
                            if (p == 6'd1) begin
                                scl_next = 1'b1;
                            end else begin
                                scl_next = 1'b0;
                            end
                        end
                        default: scl_next = scl_reg;
                    endcase
                end
            end else begin
                tick_next = tick_reg + 16'd1;
            end
        end
    end

    // Engine state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg   <= CMD_NONE;
            phase_reg <= 6'd0;
            sub_reg   <= 2'd0;
            tick_reg  <= 16'd0;
            shift_reg <= 8'd0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            ack_reg   <= 1'b0;
            rx_reg    <= 8'd0;
            ackl_reg  <= 1'b0;
        end else begin
            cmd_reg   <= cmd_next;
            phase_reg <= phase_next;
            sub_reg   <= sub_next;
            tick_reg  <= tick_next;
            shift_reg <= shift_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            ack_reg   <= ack_next;
            rx_reg    <= rx_next;
            ackl_reg  <= ackl_next;
        end
    end

    // Result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (pop) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_tdata_reg <= {3'b000, ack_next, rx_next, done_next,
                            (cmd_next != CMD_NONE), sda_next, scl_next};
        end
    end

    // Checks
    a_phase_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_reg != CMD_NONE) |-> (phase_reg <= last_phase(cmd_reg)))
        else $error("phase index past end of command");

    a_idle_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_reg == CMD_NONE) |-> (phase_reg == 6'd0))
        else $error("idle engine holds a phase index");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tdata_reg[3]) |-> !m_tdata_reg[2])
        else $error("completion reported while busy");

    a_pop_result: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> m_tvalid_reg)
        else $error("popped tick produced no result");

endmodule

// ===== src/i2c_master_bit_engine_top.sv =====
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_top
// Tick-driven open-drain I2C master bit engine with a decoupled request
// queue and a registered result stage.
// ----------------------------------------------------------------------------
// Usage:
//   Every request on the s_ channel is one engine tick. s_tuser carries the
//   command mode; s_tdata carries the byte to send, the ack level and the
//   sampled SDA line. A command launches only while the engine is idle.
//   Every tick returns exactly one result on the m_ channel with the SCL and
//   SDA levels, busy, done, the last read byte and the last ack seen.
//   Throughput: one tick per clock cycle while the result side is not
//   stalled by m_tready. A request accepted into the queue waits there
//   until the engine steps it; its result is then registered in the result
//   stage. Each waveform phase lasts cfg_wdata ticks (zero counts as one).
//   It is to be written via cfg_we only while no request is in flight; the
//   block itself does not enforce this. A new length applies to the
//   running phase at once.
//   Reset: queue empty, engine idle, SCL and SDA released, phase length 50.
//   Stall: when m_tready is low the result stays put, the two-entry queue
//   fills and s_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [15:0]                    cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [7:0] tx_byte, [8] ack_level, [9] sda_in, [15:10] zero
    input  logic [i2cm_pkg::S_TDATA_W-1:0] s_tdata,
    // [2:0] mode
    input  logic [i2cm_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] scl_level, [1] sda_level, [2] busy_res, [3] done_res,
    // [11:4] rx_byte, [12] ack_seen, [15:13] zero
    output logic [i2cm_pkg::M_TDATA_W-1:0] m_tdata
);
    import i2cm_pkg::*;

    logic [15:0] phase_ticks_reg;
    logic        q_valid;
    logic        q_ready;
    tick_t       q_data;

    // Phase length register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_ticks_reg <= PHASE_TICKS_RST;
        end else if (cfg_we) begin
            phase_ticks_reg <= cfg_wdata;
        end
    end

    i2cm_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data)
    );

    i2cm_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .phase_ticks (phase_ticks_reg),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_data      (q_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

// ===== sim/i2c_bit_engine_checker.sv =====
// ----------------------------------------------------------------------------
// i2c_bit_engine_checker
// Watches both stream channels and the phase-length write port of the I2C
// master bit engine. Each accepted tick request is run through a local model
// of the engine. The bus view that the model predicts is queued, and each
// accepted result is compared with the oldest queued view, field by field.
// ----------------------------------------------------------------------------
module i2c_bit_engine_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    output int          fail_count,
    output int          pending,
    output logic        model_busy
);
    timeunit 1ns;
    timeprecision 1ps;
    import i2cm_pkg::*;

    localparam logic [15:0] DEFAULT_PHASE_LEN = 16'd50;

    // Outputs of the engine after one tick
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] rx;
        logic       ack;
    } bus_view_t;

    bus_view_t   bus_views[$];
    int          results_seen;

    // Engine model state
    cmd_t        run_cmd;
    logic [5:0]  phase;
    logic [15:0] ticks_in_phase;
    logic [7:0]  shreg;
    logic        scl_q;
    logic        sda_q;
    logic        ack_q;
    logic [7:0]  rx_q;
    logic        ack_lvl_q;
    logic [15:0] phase_len;

    // Number of waveform phases of each command
    function automatic logic [5:0] phase_total(input cmd_t c);
        case (c)
            CMD_START: return 6'd4;
            CMD_STOP:  return 6'd3;
            CMD_WRITE: return 6'd28;
            CMD_READ:  return 6'd33;
            CMD_ACK:   return 6'd3;
            default:   return 6'd0;
        endcase
    endfunction

    // Line changes and samples on the first tick of phase p
    task automatic apply_phase(input logic [5:0] p, input logic sda_in);
        int r;
        int q;
        case (run_cmd)
            CMD_START: begin
                case (p)
                    6'd0:    sda_q = 1'b1;
                    6'd1:    scl_q = 1'b1;
                    6'd2:    sda_q = 1'b0;
                    default: scl_q = 1'b0;
                endcase
            end
            CMD_STOP: begin
                case (p)
                    6'd0:    sda_q = 1'b0;
                    6'd1:    scl_q = 1'b1;
                    default: sda_q = 1'b1;
                endcase
            end
            CMD_WRITE: begin
                if (p < 6'd24) begin
                    r = int'(p) % 3;
                    if (r == 0) begin
                        sda_q = shreg[7];
                        shreg = {shreg[6:0], 1'b0};
                    end else if (r == 1) begin
                        scl_q = 1'b1;
                    end else begin
                        scl_q = 1'b0;
                    end
                end else begin
                    // SDA released ahead of the acknowledge clock
                    q = int'(p) - 24;
                    if (q == 0)      sda_q = 1'b1;
                    else if (q == 1) scl_q = 1'b1;
                    else if (q == 2) ack_q = ~sda_in;
                    else             scl_q = 1'b0;
                end
            end
            CMD_READ: begin
                if (p == 6'd0) begin
                    sda_q = 1'b1;
                end else if (p == 6'd32) begin
                    scl_q = 1'b0;
                end else begin
                    r = (int'(p) - 1) % 4;
                    if (r == 0)      scl_q = 1'b0;
                    else if (r == 1) scl_q = 1'b1;
                    else if (r == 2) shreg = {shreg[6:0], sda_in};
                end
            end
            CMD_ACK: begin
                case (p)
                    6'd0:    sda_q = ~ack_lvl_q;
                    6'd1:    scl_q = 1'b1;
                    default: scl_q = 1'b0;
                endcase
            end
            default: ;
        endcase
    endtask

    // Advance the engine model by one tick and return its bus view
    task automatic engine_tick(input cmd_t mode, input logic [7:0] tx, input logic ackl,
                               input logic sda_in, output bus_view_t view);
        logic [16:0] len;
        logic        done;
        done = 1'b0;
        len  = (phase_len == 16'd0) ? 17'd1 : {1'b0, phase_len};
        if (run_cmd == CMD_NONE) begin
            // codes above the ack command count as none
            if (mode >= CMD_START && mode <= CMD_ACK) begin
                run_cmd        = mode;
                phase          = 6'd0;
                ticks_in_phase = 16'd0;
                if (mode == CMD_WRITE)     shreg = tx;
                else if (mode == CMD_READ) shreg = 8'd0;
                ack_lvl_q = ackl;
                apply_phase(6'd0, sda_in);
            end
        end else if ({1'b0, ticks_in_phase} + 17'd1 >= len) begin
            ticks_in_phase = 16'd0;
            phase          = phase + 6'd1;
            if (phase >= phase_total(run_cmd)) begin
                if (run_cmd == CMD_READ) rx_q = shreg;
                run_cmd = CMD_NONE;
                phase   = 6'd0;
                done    = 1'b1;
            end else begin
                apply_phase(phase, sda_in);
            end
        end else begin
            ticks_in_phase = ticks_in_phase + 16'd1;
        end
        view.scl  = scl_q;
        view.sda  = sda_q;
        view.busy = (run_cmd != CMD_NONE);
        view.done = done;
        view.rx   = rx_q;
        view.ack  = ack_q;
    endtask

    task automatic report(input string what, input int got, input int want);
        $display("mismatch on result %0d: %s got %0h expected %0h",
                 results_seen, what, got, want);
        fail_count++;
    endtask

    // Compare results first, then queue the view of a newly accepted request
    always @(posedge aclk) begin
        bus_view_t want;
        bus_view_t view;
        if (!aresetn) begin
            bus_views.delete();
            run_cmd        = CMD_NONE;
            phase          = 6'd0;
            ticks_in_phase = 16'd0;
            shreg          = 8'd0;
            scl_q          = 1'b1;
            sda_q          = 1'b1;
            ack_q          = 1'b0;
            rx_q           = 8'd0;
            ack_lvl_q      = 1'b0;
            phase_len      = DEFAULT_PHASE_LEN;
            results_seen   = 0;
            fail_count     = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (bus_views.size() == 0) begin
                    report("unexpected result", int'(m_tdata), 0);
                end else begin
                    want = bus_views.pop_front();
                    if (m_tdata[0] !== want.scl)
                        report("scl_level", int'(m_tdata[0]), int'(want.scl));
                    if (m_tdata[1] !== want.sda)
                        report("sda_level", int'(m_tdata[1]), int'(want.sda));
                    if (m_tdata[2] !== want.busy)
                        report("busy", int'(m_tdata[2]), int'(want.busy));
                    if (m_tdata[3] !== want.done)
                        report("done", int'(m_tdata[3]), int'(want.done));
                    if (m_tdata[11:4] !== want.rx)
                        report("rx_byte", int'(m_tdata[11:4]), int'(want.rx));
                    if (m_tdata[12] !== want.ack)
                        report("ack_seen", int'(m_tdata[12]), int'(want.ack));
                end
                results_seen++;
            end
            if (cfg_we) phase_len = cfg_wdata;
            if (s_tvalid && s_tready) begin
                engine_tick(s_tuser, s_tdata[7:0], s_tdata[8], s_tdata[9], view);
                bus_views.push_back(view);
            end
        end
        pending    = bus_views.size();
        model_busy = (run_cmd != CMD_NONE);
    end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus for the I2C master bit engine. Commands are issued only while the
// engine is idle and then fed ticks until they complete: one start at the
// reset phase length, a directed pass at one tick per phase, a start at the
// longest phase length cut short by a new length, then random transactions
// with noise at short phase lengths. Both channels idle at random; the
// result side also holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import i2cm_pkg::*;

    localparam int          HOLD_CYCLES = 64;
    localparam int          CALM_TICKS  = 60;
    localparam int unsigned CYCLE_LIMIT = 40_000;
    // SDA line level while a command runs
    localparam int          SDA_LOW  = 0;
    localparam int          SDA_HIGH = 1;
    localparam int          SDA_RAND = 2;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [15:0]          cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // [7:0] tx_byte, [8] ack_level, [9] sda_in
    logic [S_TUSER_W-1:0] s_tuser;   // [2:0] mode
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // scl, sda, busy, done, rx_byte[7:0], ack_seen

    int          fail_count;
    int          pending;
    logic        model_busy;
    bit          calm = 1'b0;
    bit          hold_request = 1'b0;
    int          sent = 0;
    int unsigned cycles = 0;

    i2c_master_bit_engine_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    i2c_bit_engine_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending),
        .model_busy (model_busy)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: random backpressure, one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else if (calm) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= 22);
            end
        end
    end

    function automatic logic pick_sda(input int how);
        if (how == SDA_LOW)  return 1'b0;
        if (how == SDA_HIGH) return 1'b1;
        return 1'($urandom);
    endfunction

    // One tick request; returns on the falling edge after it is taken
    task automatic send_tick(input cmd_t mode, input logic [7:0] tx, input logic ackl,
                             input logic sda);
        while (!calm && $urandom_range(0, 99) < 22) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {6'd0, sda, ackl, tx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
        @(negedge aclk);
    endtask

    // Launch a command and tick the engine until it is idle again.
    // With noise, the ticks during the command carry random codes.
    task automatic issue_command(input cmd_t mode, input logic [7:0] tx, input logic ackl,
                                 input int sda_how, input bit noisy);
        send_tick(mode, tx, ackl, pick_sda(sda_how));
        while (model_busy)
            send_tick(noisy ? cmd_t'($urandom_range(0, 7)) : CMD_NONE, 8'($urandom),
                      1'($urandom), pick_sda(sda_how));
    endtask

    // Phase length write once every result is back
    task automatic set_phase_len(input logic [15:0] len);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_wdata <= len;
        cfg_we    <= 1'b1;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // A bus transaction with random content; now and then a stray command
    // or a transaction without its stop
    task automatic random_transaction();
        logic [7:0] addr;
        int         n;
        bit         noisy;
        noisy = 1'($urandom);
        if ($urandom_range(0, 9) == 0) begin
            issue_command(cmd_t'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                          SDA_RAND, noisy);
            return;
        end
        addr = 8'($urandom);
        issue_command(CMD_START, 8'($urandom), 1'($urandom), SDA_RAND, noisy);
        issue_command(CMD_WRITE, addr, 1'($urandom), SDA_RAND, noisy);
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) begin
            if (addr[0]) begin
                issue_command(CMD_READ, 8'($urandom), 1'($urandom), SDA_RAND, noisy);
                issue_command(CMD_ACK, 8'($urandom),
                              (k != n - 1) ? 1'b1 : 1'($urandom), SDA_RAND, noisy);
            end else begin
                issue_command(CMD_WRITE, 8'($urandom), 1'($urandom), SDA_RAND, noisy);
            end
        end
        if ($urandom_range(0, 7) != 0)
            issue_command(CMD_STOP, 8'($urandom), 1'($urandom), SDA_RAND, noisy);
        repeat ($urandom_range(0, 2))
            send_tick(CMD_NONE, 8'($urandom), 1'($urandom), 1'($urandom));
    endtask

    // Random transactions until about count more ticks have gone in
    task automatic run_random(input int count, input bit with_hold);
        int goal;
        goal = sent + count;
        if (with_hold) hold_request = 1'b1;
        while (sent < goal) begin
            random_transaction();
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 16'd0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_NONE;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // One start at the reset phase length
        issue_command(CMD_START, 8'h00, 1'b0, SDA_RAND, 1'b1);

        // Directed pass at one tick per phase
        set_phase_len(16'd1);
        issue_command(CMD_START, 8'h00, 1'b0, SDA_RAND, 1'b1);
        issue_command(CMD_WRITE, 8'hFF, 1'b0, SDA_LOW, 1'b1);   // slave acks
        issue_command(CMD_WRITE, 8'h00, 1'b1, SDA_HIGH, 1'b1);  // slave nacks
        issue_command(CMD_WRITE, 8'hA5, 1'b0, SDA_RAND, 1'b1);
        issue_command(CMD_READ, 8'h00, 1'b0, SDA_HIGH, 1'b1);
        issue_command(CMD_ACK, 8'h00, 1'b1, SDA_RAND, 1'b1);
        issue_command(CMD_READ, 8'hFF, 1'b1, SDA_LOW, 1'b1);
        issue_command(CMD_ACK, 8'hFF, 1'b0, SDA_RAND, 1'b1);
        issue_command(CMD_READ, 8'h5A, 1'b0, SDA_RAND, 1'b1);
        issue_command(CMD_STOP, 8'h00, 1'b0, SDA_RAND, 1'b1);
        // unused codes and out-of-sequence commands
        issue_command(cmd_t'(3'd6), 8'hFF, 1'b1, SDA_HIGH, 1'b0);
        issue_command(cmd_t'(3'd7), 8'h00, 1'b0, SDA_LOW, 1'b0);
        issue_command(CMD_NONE, 8'hFF, 1'b1, SDA_HIGH, 1'b0);
        issue_command(CMD_ACK, 8'h00, 1'b1, SDA_RAND, 1'b0);
        issue_command(CMD_STOP, 8'hFF, 1'b1, SDA_RAND, 1'b0);

        // Longest phase with no idling on either side, then a short length
        // written while the start is still in its first phase
        set_phase_len(16'hFFFF);
        calm = 1'b1;
        send_tick(CMD_START, 8'h00, 1'b0, 1'($urandom));
        repeat (CALM_TICKS)
            send_tick(CMD_NONE, 8'($urandom), 1'($urandom), 1'($urandom));
        calm = 1'b0;
        set_phase_len(16'd1);
        while (model_busy)
            send_tick(CMD_NONE, 8'($urandom), 1'($urandom), 1'($urandom));

        // Zero acts as one tick per phase
        set_phase_len(16'd0);
        run_random(40, 1'b0);
        set_phase_len(16'd1);
        run_random(100, 1'b1);
        set_phase_len(16'd2);
        run_random(30, 1'b0);

        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
